// ----- hw/rtl/bks_pkg.sv -----
// ----------------------------------------------------------------------------
// bks_pkg
// Shared types and constants for the box-kernel smoother.
// ----------------------------------------------------------------------------
package bks_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned LOC_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned BW_W      = 16;
  localparam int unsigned KIND_W    = 2;

  localparam logic [BW_W-1:0] BW_RESET = 16'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PREP,
    ST_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic query_start;
    logic scan_rd;
    logic prep;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic scan_last;
    logic pipe_busy;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/bks_ctrl.sv -----
// ----------------------------------------------------------------------------
// bks_ctrl
// Sequencer: accepts items, runs the table scan and the divide per query.
// ----------------------------------------------------------------------------
module bks_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic [bks_pkg::KIND_W-1:0]  kind,
  output logic                        s_tready,
  input  bks_pkg::sts_t               sts,
  output bks_pkg::cmd_t               cmd
);

  bks_pkg::state_t state, state_next;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bks_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == bks_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      bks_pkg::ST_IDLE: begin
        if (accept) begin
          case (bks_pkg::kind_t'(kind))
            bks_pkg::KIND_LOAD: begin
              cmd.load = !sts.full;
            end
            bks_pkg::KIND_CLEAR: begin
              cmd.clear = 1'b1;
            end
            bks_pkg::KIND_QUERY: begin
              cmd.query_start = 1'b1;
              state_next      = sts.cnt_zero ? bks_pkg::ST_PREP : bks_pkg::ST_SCAN;
            end
            default: ;  // unused kind: dropped
          endcase
        end
      end
      bks_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = bks_pkg::ST_DRAIN;
        end
      end
      bks_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = bks_pkg::ST_PREP;
        end
      end
      bks_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = bks_pkg::ST_INIT;
      end
      bks_pkg::ST_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = bks_pkg::ST_DIV;
      end
      bks_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = bks_pkg::ST_DONE;
        end
      end
      bks_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bks_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bks_dpath.sv -----
// ----------------------------------------------------------------------------
// bks_dpath
// Observation table, window scan pipeline, accumulator, bit-serial divider
// and output register.
// ----------------------------------------------------------------------------
module bks_dpath #(
  parameter int unsigned DEPTH = bks_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bks_pkg::BW_W-1:0]   cfg_wdata,
  input  logic [bks_pkg::LOC_W-1:0]  in_loc,
  input  logic [bks_pkg::VAL_W-1:0]  in_val,
  input  bks_pkg::cmd_t              cmd,
  output bks_pkg::sts_t              sts,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,
  output logic                       m_tuser
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned ACC_W = bks_pkg::VAL_W + CW;
  localparam int unsigned NUM_W = ACC_W + 1;
  localparam int unsigned SW    = $clog2(NUM_W + 1);
  localparam int unsigned LW    = bks_pkg::LOC_W;
  localparam int unsigned VW    = bks_pkg::VAL_W;
  localparam int unsigned BW    = bks_pkg::BW_W;

  // table
  logic [LW+VW-1:0] mem [DEPTH];
  logic [CW-1:0]    count;
  logic [AW-1:0]    rd_addr;

  // query context
  logic [BW-1:0]    bandwidth;
  logic [BW-1:0]    bw_eff;
  logic [LW-1:0]    q_loc;
  logic [LW:0]      win_lo;   // may go below zero: msb set
  logic [LW:0]      win_hi;

  // scan pipeline
  logic             v1, v2, hit2;
  logic [LW+VW-1:0] rd_data;
  logic [VW-1:0]    val2;
  logic             hit1;
  logic signed [ACC_W-1:0] acc;

  // divider
  logic             neg;
  logic [ACC_W-1:0] mag;
  logic [NUM_W-1:0] nq;
  logic [BW:0]      rem;
  logic [BW+1:0]    rem_sh;
  logic [BW:0]      dvs;
  logic [SW-1:0]    step_cnt;

  logic             sat_pos, sat_neg;
  logic [31:0]      res;

  assign bw_eff = (bandwidth == '0) ? BW'(1) : bandwidth;
  assign dvs    = {bw_eff, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      bandwidth <= bks_pkg::BW_RESET;
    end else if (cfg_we) begin
      bandwidth <= cfg_wdata;
    end
  end

  // table write and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[count[AW-1:0]] <= {in_val, in_loc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count + CW'(1);
    end
  end

  // query set-up: window bounds held for the scan
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_loc  <= in_loc;
      win_lo <= {1'b0, in_loc} - (LW+1)'(bandwidth >> 1);
      win_hi <= {1'b0, in_loc} + (LW+1)'(bandwidth >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      rd_addr <= '0;
    end else if (cmd.scan_rd) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign hit1 = (win_lo[LW] || (rd_data[LW-1:0] >= win_lo[LW-1:0])) &&
                ({1'b0, rd_data[LW-1:0]} <= win_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    hit2 <= hit1;
    val2 <= rd_data[LW+VW-1:LW];
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      acc <= '0;
    end else if (v2 && hit2) begin
      acc <= acc + {{(ACC_W-VW){val2[VW-1]}}, val2};
    end
  end

  // sign and magnitude, then restoring division of (2|s| + bw) by 2bw
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg <= acc[ACC_W-1];
      mag <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
  end

  assign rem_sh = {rem, nq[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      nq       <= {mag, 1'b0} + NUM_W'(bw_eff);
      rem      <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + SW'(1);
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= (BW+1)'(rem_sh - {1'b0, dvs});
        nq  <= {nq[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[BW:0];
        nq  <= {nq[NUM_W-2:0], 1'b0};
      end
    end
  end

  // quotient now in nq
  assign sat_pos = !neg && (|nq[NUM_W-1:31]);
  assign sat_neg = neg && ((|nq[NUM_W-1:32]) || (nq[31] && (|nq[30:0])));

  always_comb begin
    if (sat_pos) begin
      res = 32'h7FFF_FFFF;
    end else if (sat_neg) begin
      res = 32'h8000_0000;
    end else if (neg) begin
      res = -nq[31:0];
    end else begin
      res = nq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {res, q_loc};
      m_tuser <= sat_pos || sat_neg;
    end
  end

  assign sts.full      = (count == CW'(DEPTH));
  assign sts.cnt_zero  = (count == '0);
  assign sts.scan_last = ((CW'(rd_addr) + CW'(1)) == count);
  assign sts.pipe_busy = v1 || v2;
  assign sts.div_last  = (step_cnt == SW'(NUM_W - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("table count beyond depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> (CW'(rd_addr) < count))
    else $error("scan read past stored entries");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |-> (!v1 && !v2))
    else $error("divide started with scan still in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

endmodule

// ----- hw/rtl/box_kernel_smoother_top.sv -----
// ----------------------------------------------------------------------------
// box_kernel_smoother_top
// Box-kernel smoother over sparse integer locations, signed Q32.0 output.
// ----------------------------------------------------------------------------
//  port group     dir  content
//  s_*            in   tuser: kind[1:0]; tdata: location[31:0], value[63:32]
//  m_*            out  tdata: query_location[31:0], smoothed[63:32];
//                      tuser: saturated
//  cfg_*          in   bandwidth register write
//
//  Load, clear and unused kinds leave the sequencer idle. A query reads the
//  table once per stored entry (the scan is skipped with the table empty),
//  drains the scan pipeline, then runs a restoring divider retiring one
//  quotient bit per cycle (a 44-bit quotient at depth 1024). rst is
//  synchronous; it empties the table and sets bandwidth to 5. A result waits
//  in the output register; loads and clears are still taken, a following
//  query holds at its end until the result has been transferred.
// ----------------------------------------------------------------------------
module box_kernel_smoother_top #(
  parameter int unsigned DEPTH = bks_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // location[31:0], value[63:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // query_location[31:0], smoothed[63:32]
  output logic        m_tuser    // saturated
);

  bks_pkg::cmd_t cmd;
  bks_pkg::sts_t sts;

  bks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bks_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_loc    (s_tdata[31:0]),
    .in_val    (s_tdata[63:32]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
